[sv/aspf_pkg.sv]
// Shared constants, types and helpers for the angular spring force unit.
package aspf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COS_FRAC  = 16;
  localparam int IN_W      = 32;
  localparam int COS_W     = 18;
  localparam int D_W       = IN_W + 1;
  localparam int SQ_IN_W   = 70;
  localparam int SQ_W      = SQ_IN_W / 2;
  localparam int DV_NUM_W  = 88;
  localparam int DV_DEN_W  = D_W;
  localparam int DV_Q_W    = 56;
  localparam int SQ_LAT    = SQ_W;
  localparam int DV_LAT    = DV_Q_W;
  localparam int RD_LAT    = DV_LAT - SQ_LAT;
  localparam int TOTAL_LAT = SQ_LAT + 2 * DV_LAT + 12;
  localparam int M_W       = 54;
  localparam int M_HALF    = M_W / 2;

  localparam logic [1:0] REG_STIFFNESS = 2'd0;
  localparam logic [1:0] REG_DAMPING   = 2'd1;
  localparam logic [1:0] REG_COS_REST  = 2'd2;

  typedef struct packed {
    logic signed [D_W-1:0] lx;
    logic signed [D_W-1:0] ly;
    logic signed [D_W-1:0] dvx;
    logic signed [D_W-1:0] dvy;
  } sqside_t;

  typedef struct packed {
    logic [D_W-1:0]        len;
    logic                  dneg;
    logic signed [D_W-1:0] lx;
    logic signed [D_W-1:0] ly;
  } dvside_t;

  typedef struct packed {
    logic negx;
    logic negy;
    logic degen;
  } outside_t;

  function automatic logic [D_W-1:0] mag33(logic signed [D_W-1:0] v);
    return v[D_W-1] ? D_W'(-v) : D_W'(v);
  endfunction

endpackage

[sv/angular_spring_force_unit.sv]
// Top level: damped spring force between outer particles with law-of-cosines rest length.
// One word enters per clock and its result leaves with done high for one cycle; the delay
// is set by the root pipeline for the side lengths and by the two divider pipelines
// that form the velocity projection and the final force components. Busy is high only
// during reset; results cannot be held off, so nothing in the block stalls.
module angular_spring_force_unit import aspf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic signed [IN_W-1:0]  p1_pos_x,
  input  logic signed [IN_W-1:0]  p1_pos_y,
  input  logic signed [IN_W-1:0]  p2_pos_x,
  input  logic signed [IN_W-1:0]  p2_pos_y,
  input  logic signed [IN_W-1:0]  p3_pos_x,
  input  logic signed [IN_W-1:0]  p3_pos_y,
  input  logic signed [IN_W-1:0]  p1_vel_x,
  input  logic signed [IN_W-1:0]  p1_vel_y,
  input  logic signed [IN_W-1:0]  p3_vel_x,
  input  logic signed [IN_W-1:0]  p3_vel_y,
  output logic                    done,
  output logic signed [IN_W-1:0]  force_x,
  output logic signed [IN_W-1:0]  force_y,
  output logic                    degenerate,
  output logic                    saturated
);

  logic [31:0]             stiffness;
  logic [31:0]             damping;
  logic signed [COS_W-1:0] cos_rest_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness      <= 32'(1) << FRAC_BITS;
      damping        <= '0;
      cos_rest_angle <= COS_W'(1) << COS_FRAC;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STIFFNESS: stiffness <= cfg_data;
        REG_DAMPING:   damping <= cfg_data;
        REG_COS_REST:  cos_rest_angle <= cfg_data[COS_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic                  v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;
  logic signed [D_W-1:0] l1x, l1y, l2x, l2y;
  sqside_t               s1_side, s2_side, s3_side;
  logic [65:0]           sq_l1x, sq_l1y, sq_l2x, sq_l2y, sq_lx, sq_ly;
  logic [65:0]           len_l1, len_l2, len_l;
  logic [SQ_W-1:0]       root_l, root_b, root_c, root_r;
  sqside_t               da [SQ_LAT];
  logic [SQ_LAT-1:0]     va;
  logic [65:0]           bb, cc, bc, px, py;
  logic [D_W-1:0]        s4_len, s5_len, s6_len;
  logic                  s4_nx, s4_ny;
  logic signed [D_W-1:0] s4_lx, s4_ly, s5_lx, s5_ly, s6_lx, s6_ly;
  logic [66:0]           s5_sum, s6_sum, dm5, dm6, dm7;
  logic [50:0]           bcl, bch;
  logic                  s5_csn, s6_csn, dneg5, dneg6;
  logic [68:0]           t6;
  logic [SQ_IN_W-1:0]    r2;
  dvside_t               s7_side;
  logic [DV_Q_W-1:0]     quo_p, qx, qy;
  logic [SQ_W-1:0]       rd [RD_LAT];
  dvside_t               db [DV_LAT];
  logic [DV_LAT-1:0]     vb;
  logic                  e_neg, s8_dneg;
  logic [66:0]           pe, pd;
  logic [D_W-1:0]        s8_len, s9_len, s10_len, s11_len;
  logic signed [D_W-1:0] s8_lx, s8_ly, s9_lx, s9_ly;
  logic signed [M_W-1:0] m9;
  logic [59:0]           pxl, pxh, pyl, pyh;
  outside_t              s10_side, s11_side;
  logic [DV_NUM_W-1:0]   numx, numy;
  outside_t              dc [DV_LAT];
  logic [DV_LAT-1:0]     vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
    end else begin
      v1  <= start && !busy;
      v2  <= v1;
      v3  <= v2;
      v4  <= va[SQ_LAT-1];
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= vb[DV_LAT-1];
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    l1x <= D_W'(p1_pos_x) - D_W'(p2_pos_x);
    l1y <= D_W'(p1_pos_y) - D_W'(p2_pos_y);
    l2x <= D_W'(p2_pos_x) - D_W'(p3_pos_x);
    l2y <= D_W'(p2_pos_y) - D_W'(p3_pos_y);
    s1_side.lx  <= D_W'(p1_pos_x) - D_W'(p3_pos_x);
    s1_side.ly  <= D_W'(p1_pos_y) - D_W'(p3_pos_y);
    s1_side.dvx <= D_W'(p1_vel_x) - D_W'(p3_vel_x);
    s1_side.dvy <= D_W'(p1_vel_y) - D_W'(p3_vel_y);
  end

  always_ff @(posedge clk) begin
    sq_l1x <= mag33(l1x) * mag33(l1x);
    sq_l1y <= mag33(l1y) * mag33(l1y);
    sq_l2x <= mag33(l2x) * mag33(l2x);
    sq_l2y <= mag33(l2y) * mag33(l2y);
    sq_lx  <= mag33(s1_side.lx) * mag33(s1_side.lx);
    sq_ly  <= mag33(s1_side.ly) * mag33(s1_side.ly);
    s2_side <= s1_side;
    len_l1 <= sq_l1x + sq_l1y;
    len_l2 <= sq_l2x + sq_l2y;
    len_l  <= sq_lx + sq_ly;
    s3_side <= s2_side;
  end

  aspf_sqrt u_sqrt_l (.clk(clk), .x(SQ_IN_W'(len_l)), .root(root_l));
  aspf_sqrt u_sqrt_b (.clk(clk), .x(SQ_IN_W'(len_l1)), .root(root_b));
  aspf_sqrt u_sqrt_c (.clk(clk), .x(SQ_IN_W'(len_l2)), .root(root_c));

  always_ff @(posedge clk) begin
    da[0] <= s3_side;
    for (int i = 1; i < SQ_LAT; i++) begin
      da[i] <= da[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else begin
      va <= {va[SQ_LAT-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    bb <= root_b[D_W-1:0] * root_b[D_W-1:0];
    cc <= root_c[D_W-1:0] * root_c[D_W-1:0];
    bc <= root_b[D_W-1:0] * root_c[D_W-1:0];
    px <= mag33(da[SQ_LAT-1].lx) * mag33(da[SQ_LAT-1].dvx);
    py <= mag33(da[SQ_LAT-1].ly) * mag33(da[SQ_LAT-1].dvy);
    s4_nx <= da[SQ_LAT-1].lx[D_W-1] != da[SQ_LAT-1].dvx[D_W-1];
    s4_ny <= da[SQ_LAT-1].ly[D_W-1] != da[SQ_LAT-1].dvy[D_W-1];
    s4_len <= root_l[D_W-1:0];
    s4_lx <= da[SQ_LAT-1].lx;
    s4_ly <= da[SQ_LAT-1].ly;
  end

  logic [COS_W-1:0] cos_mag;
  assign cos_mag = cos_rest_angle[COS_W-1] ? COS_W'(-cos_rest_angle) : COS_W'(cos_rest_angle);

  always_ff @(posedge clk) begin
    s5_sum <= 67'(bb) + 67'(cc);
    bcl <= bc[32:0] * cos_mag;
    bch <= bc[65:33] * cos_mag;
    s5_csn <= cos_rest_angle[COS_W-1];
    if (s4_nx == s4_ny) begin
      dm5 <= 67'(px) + 67'(py);
      dneg5 <= s4_nx;
    end else if (px >= py) begin
      dm5 <= 67'(px - py);
      dneg5 <= s4_nx;
    end else begin
      dm5 <= 67'(py - px);
      dneg5 <= s4_ny;
    end
    s5_len <= s4_len;
    s5_lx <= s4_lx;
    s5_ly <= s4_ly;
  end

  logic [83:0] t_full;
  assign t_full = (84'(bch) << 33) + 84'(bcl);

  always_ff @(posedge clk) begin
    t6 <= t_full[83:COS_FRAC-1];
    s6_sum <= s5_sum;
    s6_csn <= s5_csn;
    dm6 <= dm5;
    dneg6 <= dneg5;
    s6_len <= s5_len;
    s6_lx <= s5_lx;
    s6_ly <= s5_ly;
  end

  always_ff @(posedge clk) begin
    if (s6_csn) begin
      r2 <= SQ_IN_W'(s6_sum) + SQ_IN_W'(t6);
    end else if (SQ_IN_W'(s6_sum) <= SQ_IN_W'(t6)) begin
      r2 <= '0;
    end else begin
      r2 <= SQ_IN_W'(s6_sum) - SQ_IN_W'(t6);
    end
    dm7 <= dm6;
    s7_side.len <= s6_len;
    s7_side.dneg <= dneg6;
    s7_side.lx <= s6_lx;
    s7_side.ly <= s6_ly;
  end

  aspf_sqrt u_sqrt_r (.clk(clk), .x(r2), .root(root_r));
  aspf_div u_div_p (.clk(clk), .num(DV_NUM_W'(dm7)), .den(s7_side.len), .quo(quo_p));

  always_ff @(posedge clk) begin
    rd[0] <= root_r;
    for (int i = 1; i < RD_LAT; i++) begin
      rd[i] <= rd[i-1];
    end
    db[0] <= s7_side;
    for (int i = 1; i < DV_LAT; i++) begin
      db[i] <= db[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else begin
      vb <= {vb[DV_LAT-2:0], v7};
    end
  end

  logic signed [35:0] e8;
  logic [34:0]        e8_mag;
  assign e8 = $signed({3'b000, db[DV_LAT-1].len}) - $signed({1'b0, rd[RD_LAT-1]});
  assign e8_mag = e8[35] ? 35'(-e8) : 35'(e8);

  always_ff @(posedge clk) begin
    e_neg <= e8[35];
    pe <= stiffness * e8_mag;
    pd <= damping * quo_p[34:0];
    s8_dneg <= db[DV_LAT-1].dneg;
    s8_len <= db[DV_LAT-1].len;
    s8_lx <= db[DV_LAT-1].lx;
    s8_ly <= db[DV_LAT-1].ly;
  end

  logic [50:0]           smag, dmag;
  logic signed [M_W-1:0] sv, dv;
  always_comb begin
    smag = 51'(pe >> FRAC_BITS);
    dmag = 51'(pd >> FRAC_BITS);
    sv = e_neg ? -$signed(M_W'(smag)) : $signed(M_W'(smag));
    dv = s8_dneg ? -$signed(M_W'(dmag)) : $signed(M_W'(dmag));
  end

  always_ff @(posedge clk) begin
    m9 <= sv + dv;
    s9_len <= s8_len;
    s9_lx <= s8_lx;
    s9_ly <= s8_ly;
  end

  logic [M_W-1:0] mm;
  assign mm = m9[M_W-1] ? M_W'(-m9) : M_W'(m9);

  always_ff @(posedge clk) begin
    pxl <= mm[M_HALF-1:0] * mag33(s9_lx);
    pxh <= mm[M_W-1:M_HALF] * mag33(s9_lx);
    pyl <= mm[M_HALF-1:0] * mag33(s9_ly);
    pyh <= mm[M_W-1:M_HALF] * mag33(s9_ly);
    s10_side.negx <= m9[M_W-1] == s9_lx[D_W-1];
    s10_side.negy <= m9[M_W-1] == s9_ly[D_W-1];
    s10_side.degen <= s9_len == '0;
    s10_len <= s9_len;
  end

  always_ff @(posedge clk) begin
    numx <= (DV_NUM_W'(pxh) << M_HALF) + DV_NUM_W'(pxl);
    numy <= (DV_NUM_W'(pyh) << M_HALF) + DV_NUM_W'(pyl);
    s11_side <= s10_side;
    s11_len <= s10_len;
  end

  aspf_div u_div_x (.clk(clk), .num(numx), .den(s11_len), .quo(qx));
  aspf_div u_div_y (.clk(clk), .num(numy), .den(s11_len), .quo(qy));

  always_ff @(posedge clk) begin
    dc[0] <= s11_side;
    for (int i = 1; i < DV_LAT; i++) begin
      dc[i] <= dc[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= '0;
    end else begin
      vc <= {vc[DV_LAT-2:0], v11};
    end
  end

  function automatic logic [IN_W:0] clip(logic [DV_Q_W-1:0] q, logic neg);
    logic [IN_W:0] r;
    if (neg) begin
      if (q > DV_Q_W'(33'h1_0000_0000 >> 1)) begin
        r = {1'b1, 1'b1, {(IN_W-1){1'b0}}};
      end else begin
        r = {1'b0, IN_W'(-q[IN_W-1:0])};
      end
    end else begin
      if (q > DV_Q_W'({(IN_W-1){1'b1}})) begin
        r = {1'b1, 1'b0, {(IN_W-1){1'b1}}};
      end else begin
        r = {1'b0, q[IN_W-1:0]};
      end
    end
    return r;
  endfunction

  logic [IN_W:0] cx, cy;
  assign cx = clip(qx, dc[DV_LAT-1].negx);
  assign cy = clip(qy, dc[DV_LAT-1].negy);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vc[DV_LAT-1];
    end
    if (dc[DV_LAT-1].degen) begin
      force_x <= '0;
      force_y <= '0;
      degenerate <= 1'b1;
      saturated <= 1'b0;
    end else begin
      force_x <= cx[IN_W-1:0];
      force_y <= cy[IN_W-1:0];
      degenerate <= 1'b0;
      saturated <= cx[IN_W] | cy[IN_W];
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("result missing at fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without accepted word");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (force_x == '0 && force_y == '0 && !saturated))
    else $error("degenerate result not zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (force_x == 32'sh7FFF_FFFF || force_x == 32'sh8000_0000 ||
                             force_y == 32'sh7FFF_FFFF || force_y == 32'sh8000_0000))
    else $error("saturated flag without clipped component");

endmodule

[sv/aspf_sqrt.sv]
// Pipelined floor integer square root, one root bit per stage.
module aspf_sqrt import aspf_pkg::*; (
  input  logic               clk,
  input  logic [SQ_IN_W-1:0] x,
  output logic [SQ_W-1:0]    root
);

  localparam int TW = SQ_IN_W + 1;

  logic [SQ_IN_W-1:0] rem [1:SQ_W];
  logic [SQ_W-1:0]    rt  [1:SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    localparam int B = SQ_W - 1 - k;
    logic [SQ_IN_W-1:0] rem_in;
    logic [SQ_W-1:0]    rt_in;
    logic [TW-1:0]      trial;
    logic               fit;
    if (k == 0) begin : g_first
      assign rem_in = x;
      assign rt_in  = '0;
    end else begin : g_rest
      assign rem_in = rem[k];
      assign rt_in  = rt[k];
    end
    assign trial = (TW'(rt_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign fit   = trial <= {1'b0, rem_in};
    always_ff @(posedge clk) begin
      rem[k+1] <= fit ? SQ_IN_W'({1'b0, rem_in} - trial) : rem_in;
      rt[k+1]  <= fit ? (rt_in | (SQ_W'(1) << B)) : rt_in;
    end
  end

  assign root = rt[SQ_W];

endmodule

[sv/aspf_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module aspf_div import aspf_pkg::*; (
  input  logic                clk,
  input  logic [DV_NUM_W-1:0] num,
  input  logic [DV_DEN_W-1:0] den,
  output logic [DV_Q_W-1:0]   quo
);

  logic [DV_DEN_W-1:0] rem [1:DV_Q_W];
  logic [DV_Q_W-1:0]   nq  [1:DV_Q_W];
  logic [DV_DEN_W-1:0] dd  [1:DV_Q_W];

  for (genvar k = 0; k < DV_Q_W; k++) begin : g_stage
    logic [DV_DEN_W-1:0] rem_in;
    logic [DV_Q_W-1:0]   nq_in;
    logic [DV_DEN_W-1:0] den_in;
    logic [DV_DEN_W:0]   t;
    logic                ge;
    if (k == 0) begin : g_first
      assign rem_in = DV_DEN_W'(num[DV_NUM_W-1:DV_Q_W]);
      assign nq_in  = num[DV_Q_W-1:0];
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem[k];
      assign nq_in  = nq[k];
      assign den_in = dd[k];
    end
    assign t  = {rem_in, nq_in[DV_Q_W-1]};
    assign ge = t >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? DV_DEN_W'(t - {1'b0, den_in}) : t[DV_DEN_W-1:0];
      nq[k+1]  <= {nq_in[DV_Q_W-2:0], ge};
      dd[k+1]  <= den_in;
    end
  end

  assign quo = nq[DV_Q_W];

endmodule
